[rtl/core/ffba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// types and constants shared by the first-fit allocator cells and top level
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MaxBlocks = 64;
  localparam int AddrBits  = 20;
  localparam int IdxBits   = $clog2(MaxBlocks);
  localparam int CntBits   = $clog2(MaxBlocks + 1);
  localparam int SizeBits  = AddrBits + 1;
  localparam int SumBits   = AddrBits + 2;

  localparam logic [2:0] ST_REUSED     = 3'd0;
  localparam logic [2:0] ST_APPENDED   = 3'd1;
  localparam logic [2:0] ST_ZERO       = 3'd2;
  localparam logic [2:0] ST_ARENA_FULL = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_FREE       = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // token handed from cell to cell along the walk
  typedef struct packed {
    logic                active;
    logic                mode;
    logic [SumBits-1:0]  start;
    logic [SizeBits-1:0] total;
    logic [AddrBits-1:0] faddr;
    logic                hit;
    logic [SumBits-1:0]  hit_start;
    logic [IdxBits-1:0]  hit_idx;
  } token_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic                we;
    logic [IdxBits-1:0]  idx;
    logic                set_size;
    logic [SizeBits-1:0] size;
    logic                free_val;
  } cell_wr_t;

endpackage

[rtl/core/ffba_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cell
// one block table entry; inspects the passing token and forwards it
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic                            clk,
  input  logic [ffba_pkg::IdxBits-1:0]    my_idx,
  input  logic [ffba_pkg::CntBits-1:0]    block_count,
  input  logic [7:0]                      header_bytes,
  input  ffba_pkg::cell_wr_t              wr,
  input  logic                            flush,
  input  ffba_pkg::token_t                tok_in,
  output ffba_pkg::token_t                tok_out
);

  logic [ffba_pkg::SizeBits-1:0] size_r;
  logic                          free_r;
  ffba_pkg::token_t              tok_r;
  ffba_pkg::token_t              tok_nxt;
  logic                          in_use;
  logic                          match;

  always_comb begin
    in_use  = {1'b0, my_idx} < block_count;
    tok_nxt = tok_in;
    match   = 1'b0;
    if (tok_in.active && in_use && !tok_in.hit) begin
      if (tok_in.mode)
        match = (tok_in.start + ffba_pkg::SumBits'(header_bytes))
                == ffba_pkg::SumBits'(tok_in.faddr);
      else
        match = free_r && (size_r >= tok_in.total);
      if (match) begin
        tok_nxt.hit       = 1'b1;
        tok_nxt.hit_start = tok_in.start;
        tok_nxt.hit_idx   = my_idx;
      end
      tok_nxt.start = tok_in.start + ffba_pkg::SumBits'(size_r);
    end
    if (flush) tok_nxt.active = 1'b0;
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr.we && wr.idx == my_idx) begin
      if (wr.set_size) size_r <= wr.size;
      free_r <= wr.free_val;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/core/ffba_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// request sequencer: launches the token, collects it and updates the table
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [19:0]                     in_request_size,
  input  logic [19:0]                     in_free_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [19:0]                     out_data_address,
  output logic [2:0]                      out_status,
  output logic                            out_free_found,
  input  logic [7:0]                      header_bytes,
  output logic [ffba_pkg::CntBits-1:0]    block_count,
  output ffba_pkg::cell_wr_t              wr,
  output logic                            flush,
  output ffba_pkg::token_t                tok_head,
  input  ffba_pkg::token_t                tok_tail
);

  ffba_pkg::state_t               state_r, state_nxt;
  logic [ffba_pkg::CntBits-1:0]   count_r;
  logic [ffba_pkg::SumBits-1:0]   heap_r;
  logic [19:0]                    addr_r;
  logic [2:0]                     status_r;
  logic                           found_r;
  logic                           accept;
  logic                           done;
  logic [ffba_pkg::SizeBits-1:0]  total;
  logic [ffba_pkg::SumBits-1:0]   new_end;
  logic [ffba_pkg::SumBits-1:0]   res_addr;

  assign accept = in_valid && in_ready;
  assign total  = ffba_pkg::SizeBits'(in_request_size) + ffba_pkg::SizeBits'(header_bytes);
  assign done   = tok_tail.active;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          if (!in_mode && in_request_size == '0) state_nxt = ffba_pkg::S_DONE;
          else                                 state_nxt = ffba_pkg::S_WALK;
        end
      end
      ffba_pkg::S_WALK: if (done) state_nxt = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: if (out_ready) state_nxt = ffba_pkg::S_IDLE;
      default:          state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ffba_pkg::S_IDLE);
    out_valid = (state_r == ffba_pkg::S_DONE);
    flush     = (state_r != ffba_pkg::S_WALK) && !accept;
    tok_head           = '0;
    tok_head.active    = accept && !(!in_mode && in_request_size == '0);
    tok_head.mode      = in_mode;
    tok_head.total     = total;
    tok_head.faddr     = in_free_address;
    new_end  = heap_r + ffba_pkg::SumBits'(tok_tail.total);
    res_addr = '0;
    wr       = '0;
    if (state_r == ffba_pkg::S_WALK && done) begin
      if (tok_tail.hit) begin
        wr.we       = 1'b1;
        wr.idx      = tok_tail.hit_idx;
        wr.size     = '0;
        wr.free_val = tok_tail.mode;
        if (!tok_tail.mode)
          res_addr  = tok_tail.hit_start + ffba_pkg::SumBits'(header_bytes);
      end else if (!tok_tail.mode && count_r < ffba_pkg::CntBits'(ffba_pkg::MaxBlocks)
                   && new_end <= (ffba_pkg::SumBits'(1) << ffba_pkg::AddrBits)) begin
        wr.we       = 1'b1;
        wr.idx      = count_r[ffba_pkg::IdxBits-1:0];
        wr.set_size = 1'b1;
        wr.size     = tok_tail.total;
        wr.free_val = 1'b0;
        res_addr    = heap_r + ffba_pkg::SumBits'(header_bytes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_IDLE;
      count_r <= '0;
      heap_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ffba_pkg::S_WALK && done && !tok_tail.hit && !tok_tail.mode
          && wr.we) begin
        count_r <= count_r + ffba_pkg::CntBits'(1);
        heap_r  <= new_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ffba_pkg::S_IDLE && accept && !in_mode && in_request_size == '0) begin
      addr_r   <= '0;
      status_r <= ffba_pkg::ST_ZERO;
      found_r  <= 1'b0;
    end else if (state_r == ffba_pkg::S_WALK && done) begin
      addr_r  <= res_addr[19:0];
      found_r <= tok_tail.mode && tok_tail.hit;
      if (tok_tail.mode)                                      status_r <= ffba_pkg::ST_FREE;
      else if (tok_tail.hit)                                  status_r <= ffba_pkg::ST_REUSED;
      else if (count_r >= ffba_pkg::CntBits'(ffba_pkg::MaxBlocks))
                                                              status_r <= ffba_pkg::ST_TABLE_FULL;
      else if (wr.we)                                         status_r <= ffba_pkg::ST_APPENDED;
      else                                                    status_r <= ffba_pkg::ST_ARENA_FULL;
    end
  end

  assign out_data_address = addr_r;
  assign out_status       = status_r;
  assign out_free_found   = found_r;
  assign block_count      = count_r;

endmodule

[rtl/core/first_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over one arena, block table held in a chain of cells
// ----------------------------------------------------------------------------
// a request arrives on the in_ channel: mode 0 allocates request_size bytes,
// mode 1 frees the block whose data address is free_address.
// the request token walks a chain of 64 table cells, one cell per cycle.
// every request but a zero-size allocation walks the whole chain before its
// result is registered; a zero-size allocation is answered in the next cycle.
// one request is in flight at a time; the next is taken after the result
// is transferred on the out_ channel, so the block takes no new request
// before the last one is through. a stalled receiver holds the result
// and the block takes no new request until it is taken.
// cfg_ writes the header size; write it only while the block is idle.
// reset empties the table, sets the heap end to zero and the header to 16.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [19:0] in_request_size,
  input  logic [19:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_data_address,
  output logic [2:0]  out_status,
  output logic        out_free_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_header_bytes
);

  logic [7:0]                      header_r;
  logic [ffba_pkg::CntBits-1:0]    block_count;
  ffba_pkg::cell_wr_t              wr;
  logic                            flush;
  ffba_pkg::token_t                tok_head;
  ffba_pkg::token_t                tok [ffba_pkg::MaxBlocks+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)         header_r <= 8'd16;
    else if (cfg_valid) header_r <= cfg_header_bytes;
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < ffba_pkg::MaxBlocks; g++) begin : g_cell
    ffba_cell u_cell (
      .clk          (clk),
      .my_idx       (ffba_pkg::IdxBits'(g)),
      .block_count  (block_count),
      .header_bytes (header_r),
      .wr           (wr),
      .flush        (flush),
      .tok_in       (tok[g]),
      .tok_out      (tok[g+1])
    );
  end

  ffba_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_request_size  (in_request_size),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_address (out_data_address),
    .out_status       (out_status),
    .out_free_found   (out_free_found),
    .header_bytes     (header_r),
    .block_count      (block_count),
    .wr               (wr),
    .flush            (flush),
    .tok_head         (tok_head),
    .tok_tail         (tok[ffba_pkg::MaxBlocks])
  );

endmodule

[sim/tb_first_fit_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// self-checking bench for the first-fit block allocator
// ----------------------------------------------------------------------------
// requests are driven with bursty valid, results are taken with a patterned
// ready. a predictor keeps its own block table, heap end and header size
// and checks every result field by field, in order. directed requests cover
// zero size, unknown and double free, reuse, arena full and table full.
// random requests follow with header changes between phases.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

  localparam int Blocks   = 64;
  localparam int WdLimit  = 4000;

  typedef struct {
    logic [19:0] addr;
    logic [2:0]  status;
    logic        found;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [19:0] in_request_size;
  logic [19:0] in_free_address;
  logic        out_valid;
  logic        out_ready;
  logic [19:0] out_data_address;
  logic [2:0]  out_status;
  logic        out_free_found;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_header_bytes;

  // predictor state
  longint unsigned blk_size[Blocks];
  bit              blk_free[Blocks];
  int              blk_count;
  longint unsigned heap_top;
  longint unsigned hdr;

  grant_t grants_due[$];
  int     errors;
  int     burst_left;
  int     idle_cycles;

  first_fit_block_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_request_size  (in_request_size),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_address (out_data_address),
    .out_status       (out_status),
    .out_free_found   (out_free_found),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_header_bytes (cfg_header_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic grant_t allocate_or_free(logic mode, logic [19:0] size,
                                              logic [19:0] faddr);
    grant_t          g;
    longint unsigned start;
    longint unsigned total;
    start = 0;
    g.addr = '0;
    g.found = 1'b0;
    if (mode) begin
      g.status = ffba_pkg::ST_FREE;
      for (int i = 0; i < blk_count; i++) begin
        if (start + hdr == faddr) begin
          blk_free[i] = 1'b1;
          g.found = 1'b1;
          return g;
        end
        start += blk_size[i];
      end
      return g;
    end
    if (size == 0) begin
      g.status = ffba_pkg::ST_ZERO;
      return g;
    end
    total = size + hdr;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= total) begin
        blk_free[i] = 1'b0;
        g.addr = 20'(start + hdr);
        g.status = ffba_pkg::ST_REUSED;
        return g;
      end
      start += blk_size[i];
    end
    if (blk_count >= Blocks) begin
      g.status = ffba_pkg::ST_TABLE_FULL;
    end else if (heap_top + total > (64'd1 << 20)) begin
      g.status = ffba_pkg::ST_ARENA_FULL;
    end else begin
      blk_size[blk_count] = total;
      blk_free[blk_count] = 1'b0;
      blk_count++;
      g.addr = 20'(heap_top + hdr);
      g.status = ffba_pkg::ST_APPENDED;
      heap_top += total;
    end
    return g;
  endfunction

  function automatic logic [19:0] data_addr_of(int idx);
    longint unsigned start;
    start = 0;
    for (int i = 0; i < idx; i++) start += blk_size[i];
    return 20'(start + hdr);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task automatic send_req(logic mode, logic [19:0] size, logic [19:0] faddr);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid = 1'b1;
    in_mode = mode;
    in_request_size = size;
    in_free_address = faddr;
    do @(posedge clk); while (!in_ready);
    grants_due.push_back(allocate_or_free(mode, size, faddr));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (grants_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_header(logic [7:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_header_bytes = value;
    do @(posedge clk); while (!cfg_ready);
    hdr = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic free_live();
    if (blk_count == 0) send_req(1'b1, 20'($urandom), 20'($urandom));
    else send_req(1'b1, 20'($urandom), data_addr_of($urandom_range(0, blk_count - 1)));
  endtask

  task automatic test_corner_requests();
    send_req(1'b0, 20'd0, 20'd0);
    send_req(1'b1, 20'd0, 20'hFFFFF);
    send_req(1'b0, 20'd1, 20'd0);
    send_req(1'b0, 20'd100, 20'd0);
    send_req(1'b0, 20'hFFFFF, 20'd0);
    send_req(1'b1, 20'd0, data_addr_of(0));
    send_req(1'b1, 20'd0, data_addr_of(0));
    send_req(1'b1, 20'hFFFFF, 20'd5);
    send_req(1'b0, 20'd200, 20'd0);
    send_req(1'b0, 20'd1, 20'd0);
    send_req(1'b1, 20'd0, data_addr_of(1));
    send_req(1'b0, 20'd50, 20'd0);
  endtask

  task automatic test_header_extremes();
    write_header(8'd0);
    send_req(1'b0, 20'd7, 20'd0);
    send_req(1'b1, 20'd0, data_addr_of(blk_count - 1));
    send_req(1'b0, 20'd7, 20'd0);
    write_header(8'd255);
    send_req(1'b1, 20'd0, data_addr_of(0));
    send_req(1'b0, 20'd1, 20'd0);
    drain();
  endtask

  task automatic test_table_full();
    while (blk_count < Blocks) send_req(1'b0, 20'($urandom_range(1, 64)), 20'd0);
    send_req(1'b0, 20'd3000, 20'd0);
    send_req(1'b0, 20'hFFFFF, 20'd0);
  endtask

  task automatic test_random_traffic(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      if (k % 120 == 119) write_header(8'($urandom));
      pick = $urandom_range(0, 31);
      if (pick < 12) free_live();
      else if (pick < 14) send_req(1'b1, 20'($urandom), 20'($urandom));
      else if (pick == 14) send_req(1'b0, 20'd0, 20'($urandom));
      else if (pick == 15) send_req(1'b0, 20'($urandom), 20'($urandom));
      else send_req(1'b0, 20'($urandom_range(1, 2048)), 20'($urandom));
    end
  endtask

  // receiver: long ready stretches alternate with random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (($time / 4000) % 2 == 0) out_ready = 1'b1;
      else out_ready = ($urandom_range(0, 9) < 5);
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        g = grants_due.pop_front();
        if (out_data_address !== g.addr) report("data_address", out_data_address, g.addr);
        if (out_status !== g.status) report("status", out_status, g.status);
        if (out_free_found !== g.found) report("free_found", out_free_found, g.found);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    errors = 0;
    burst_left = 0;
    idle_cycles = 0;
    blk_count = 0;
    heap_top = 0;
    hdr = 16;
    for (int i = 0; i < Blocks; i++) begin
      blk_size[i] = 0;
      blk_free[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_request_size = '0;
    in_free_address = '0;
    cfg_valid = 1'b0;
    cfg_header_bytes = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_corner_requests();
    test_header_extremes();
    write_header(8'd16);
    test_table_full();
    test_random_traffic(430);
    write_header(8'd0);
    test_random_traffic(40);
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
sim/tb_first_fit_block_allocator.sv
